FILE: sv/miller_rabin_prime_test_defines.svh
// Assertion macros for the Miller-Rabin prime test block.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef MILLER_RABIN_PRIME_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_DEFINES_SVH
`ifndef SYNTH
`define MR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MR_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MR_ASSERT(label, clk, rst_n, prop, msg)
`define MR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: sv/mrpt_pkg.sv
// Shared types and constants for the Miller-Rabin prime test block.
// No dependencies.
package mrpt_pkg;
    localparam logic [31:0] LIMIT_TWO   = 32'd1373653;
    localparam logic [31:0] LIMIT_THREE = 32'd25326001;
    localparam logic [31:0] LIMIT_FOUR  = 32'd3215031751;
    localparam logic [2:0]  WIT_FIVE    = 3'd5;
    localparam logic [2:0]  WIT_SEVEN   = 3'd7;

    // A classified word handed from the front to the back.
    typedef struct packed {
        logic        done;       // answer known already, no test needed
        logic        is_prime;
        logic        out_of_range;
        logic [31:0] n;
        logic [2:0]  count;      // number of witnesses
    } t_job;

    typedef struct packed {
        logic start;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] m;
    } t_mul_req;
endpackage

FILE: sv/mrpt_front.sv
// Front part: accepts candidates, settles trivial cases and picks the witness count.
// Depends on mrpt_pkg.
module mrpt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [31:0]      i_candidate,
    output logic             o_ready,
    output logic             o_valid,
    output mrpt_pkg::t_job   o_job,
    input  logic             i_ready
);
    logic           r_full, n_full;
    mrpt_pkg::t_job r_job, n_job;

    assign o_ready = !r_full || i_ready;
    assign o_valid = r_full;
    assign o_job   = r_job;

    always_comb begin
        n_job = '0;
        n_job.n = i_candidate;
        if (i_candidate >= mrpt_pkg::LIMIT_FOUR) begin
            n_job.done = 1'b1;
            n_job.out_of_range = 1'b1;
        end else if (i_candidate < 32'd2 || !i_candidate[0] || i_candidate == 32'd3) begin
            n_job.done = 1'b1;
            n_job.is_prime = (i_candidate == 32'd2) || (i_candidate == 32'd3);
        end
        if (i_candidate < mrpt_pkg::LIMIT_TWO) n_job.count = 3'd2;
        else if (i_candidate < mrpt_pkg::LIMIT_THREE) n_job.count = 3'd3;
        else n_job.count = 3'd4;
    end

    always_comb begin
        n_full = r_full;
        if (i_ready) n_full = 1'b0;
        if (i_valid && o_ready) n_full = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_full <= 1'b0;
        else r_full <= n_full;
        if (i_valid && o_ready) r_job <= n_job;
    end
endmodule

FILE: sv/mrpt_mulmod.sv
// Shared modular multiplier: (a*b) mod m by 32 shift-add-reduce steps, one bit per cycle.
// Depends on mrpt_pkg.
module mrpt_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrpt_pkg::t_mul_req i_req,
    output logic              o_done,
    output logic [31:0]       o_result
);
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [31:0] r_a, r_b, r_m, r_acc;
    logic [32:0] dbl, dbl_red, add, add_red;

    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, r_m}) ? dbl - {1'b0, r_m} : dbl;
        add     = dbl_red + (r_a[31] ? {1'b0, r_b} : 33'd0);
        add_red = (add >= {1'b0, r_m}) ? add - {1'b0, r_m} : add;
    end

    assign o_result = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt + 6'd1;
            end
        end
        if (i_req.start) begin
            // Operand b must be reduced below m; a is taken bit by bit.
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_m   <= i_req.m;
            r_acc <= 32'd0;
        end else if (r_busy) begin
            r_acc <= add_red[31:0];
            r_a   <= {r_a[30:0], 1'b0};
        end
    end
endmodule

FILE: sv/mrpt_back.sv
// Back part: runs the witness rounds on the shared modular multiplier.
// Depends on mrpt_pkg, mrpt_mulmod and the assertion macro header.
`include "miller_rabin_prime_test_defines.svh"
module mrpt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mrpt_pkg::t_job i_job,
    output logic           o_ready,
    output logic           o_strobe,
    output logic           o_is_prime,
    output logic           o_out_of_range
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SPLIT = 7'b0000010,
        S_WIT  = 7'b0000100,
        S_POW  = 7'b0001000,
        S_WAIT = 7'b0010000,
        S_SQ   = 7'b0100000,
        S_SQW  = 7'b1000000
    } t_state;

    t_state      r_state;
    logic [31:0] r_n, r_d, r_e, r_x, r_b;
    logic [4:0]  r_s, r_k;
    logic [2:0]  r_count, r_idx;
    logic        r_sq_phase;   // 0: multiply x by b, 1: square b
    mrpt_pkg::t_mul_req mreq;
    logic        mdone;
    logic [31:0] mres;
    logic [31:0] nm1, wit;

    mrpt_mulmod u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq),
                       .o_done(mdone), .o_result(mres));

    assign nm1 = r_n - 32'd1;
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        unique case (r_idx)
            3'd0: wit = 32'd2;
            3'd1: wit = 32'd3;
            3'd2: wit = {29'd0, mrpt_pkg::WIT_FIVE};
            default: wit = {29'd0, mrpt_pkg::WIT_SEVEN};
        endcase
    end

    always_comb begin
        mreq = '0;
        mreq.m = r_n;
        if (r_state == S_POW) begin
            mreq.start = 1'b1;
            mreq.a = r_sq_phase ? r_b : r_x;
            mreq.b = r_b;
        end else if (r_state == S_SQ) begin
            mreq.start = 1'b1;
            mreq.a = r_x;
            mreq.b = r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_n <= i_job.n;
                    r_count <= i_job.count;
                    if (i_job.done) begin
                        o_strobe <= 1'b1;
                        o_is_prime <= i_job.is_prime;
                        o_out_of_range <= i_job.out_of_range;
                    end else begin
                        r_d <= i_job.n - 32'd1;
                        r_s <= 5'd0;
                        r_idx <= 3'd0;
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    if (r_d[0]) r_state <= S_WIT;
                    else begin
                        r_d <= {1'b0, r_d[31:1]};
                        r_s <= r_s + 5'd1;
                    end
                end
                S_WIT: begin
                    if (r_idx == r_count) begin
                        o_strobe <= 1'b1;
                        o_is_prime <= 1'b1;
                        o_out_of_range <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (wit == r_n) begin
                        r_idx <= r_idx + 3'd1;
                    end else begin
                        r_x <= 32'd1;
                        r_b <= wit;     // witness below n here
                        r_e <= r_d;
                        r_sq_phase <= !r_d[0];
                        r_state <= S_POW;
                    end
                end
                S_POW: r_state <= S_WAIT;
                S_WAIT: if (mdone) begin
                    if (!r_sq_phase) begin
                        r_x <= mres;
                        r_sq_phase <= 1'b1;
                        r_state <= S_POW;
                    end else begin
                        r_b <= mres;
                        r_e <= {1'b0, r_e[31:1]};
                        if (r_e[31:1] == 31'd0) begin
                            r_k <= 5'd1;
                            if (r_x == 32'd1 || r_x == nm1) begin
                                r_idx <= r_idx + 3'd1;
                                r_state <= S_WIT;
                            end else if (r_s <= 5'd1) begin
                                o_strobe <= 1'b1;
                                o_is_prime <= 1'b0;
                                o_out_of_range <= 1'b0;
                                r_state <= S_IDLE;
                            end else r_state <= S_SQ;
                        end else begin
                            r_sq_phase <= !r_e[1];
                            r_state <= S_POW;
                        end
                    end
                end
                S_SQ: r_state <= S_SQW;
                S_SQW: if (mdone) begin
                    r_x <= mres;
                    r_k <= r_k + 5'd1;
                    if (mres == nm1) begin
                        r_idx <= r_idx + 3'd1;
                        r_state <= S_WIT;
                    end else if (r_k + 5'd1 >= r_s) begin
                        o_strobe <= 1'b1;
                        o_is_prime <= 1'b0;
                        o_out_of_range <= 1'b0;
                        r_state <= S_IDLE;
                    end else r_state <= S_SQ;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `MR_ASSERT(a_ready_idle, i_clk, i_rst_n, o_ready == (r_state == S_IDLE), "ready off idle")
    `MR_ASSERT(a_onehot, i_clk, i_rst_n, $onehot(r_state), "state not one-hot")
    `MR_ASSERT(a_strobe_idle, i_clk, i_rst_n, o_strobe |-> r_state == S_IDLE, "strobe off idle")
    `MR_ASSERT(a_oor_np, i_clk, i_rst_n, o_strobe && o_out_of_range |-> !o_is_prime, "oor prime")
endmodule

FILE: sv/miller_rabin_prime_test.sv
// Top level of the deterministic 32-bit Miller-Rabin prime test.
// Depends on mrpt_pkg, mrpt_front, mrpt_back.
//   channel   direction  handshake            word
//   input     in         start / busy          i_candidate
//   result    out        o_strobe              o_is_prime, o_out_of_range
// A trivial candidate passes the front's job register and is answered from the back's
// result registers; a full test runs up to 4 witnesses, each a chain of modular
// multiplies on the bit-serial mulmod unit, after n-1 is split into d and 2^s.
// Reset is synchronous, active low, and clears all control state.
// A one-word register between front and back lets the next candidate be taken
// while the back works. Results cannot be stalled.
module miller_rabin_prime_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_candidate,
    output logic        o_strobe,
    output logic        o_is_prime,
    output logic        o_out_of_range
);
    logic           f_ready, q_valid, b_ready;
    mrpt_pkg::t_job q_job;

    assign busy = !f_ready;

    mrpt_front u_front (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start),
        .i_candidate(i_candidate), .o_ready(f_ready), .o_valid(q_valid),
        .o_job(q_job), .i_ready(b_ready));

    mrpt_back u_back (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid),
        .i_job(q_job), .o_ready(b_ready), .o_strobe(o_strobe),
        .o_is_prime(o_is_prime), .o_out_of_range(o_out_of_range));
endmodule
